>>> rtl/shift_jis_glyph_indexer_top_defines.svh
// ----------------------------------------------------------------------------
// Shift-JIS glyph indexer assertion macros
// Wrappers for the concurrent checks used by the glyph indexer RTL.
// ----------------------------------------------------------------------------
`ifndef SHIFT_JIS_GLYPH_INDEXER_TOP_DEFINES_SVH
`define SHIFT_JIS_GLYPH_INDEXER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define SJGI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SJGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SJGI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SJGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/sjgi_pkg.sv
// ----------------------------------------------------------------------------
// Shift-JIS glyph indexer package
// Byte range constants, result codes and the result record types.
// ----------------------------------------------------------------------------
package sjgi_pkg;

    localparam logic [7:0] C_DOLLAR       = 8'h24;
    localparam logic [7:0] C_UPPER_A      = 8'h41;
    localparam logic [7:0] C_UPPER_Z      = 8'h5a;
    localparam logic [7:0] C_LOWER_A      = 8'h61;
    localparam logic [7:0] C_LOWER_Z      = 8'h7a;
    localparam logic [7:0] C_ASCII_MAX    = 8'h7f;
    localparam logic [7:0] C_LEAD1_MIN    = 8'h81;
    localparam logic [7:0] C_LEAD1_MAX    = 8'h9f;
    localparam logic [7:0] C_KANA_MIN     = 8'ha1;
    localparam logic [7:0] C_KANA_MAX     = 8'hdf;
    localparam logic [7:0] C_LEAD2_MIN    = 8'he0;
    localparam logic [7:0] C_LEAD2_MAX    = 8'hef;
    localparam logic [7:0] C_LEAD2_BIAS   = 8'hc0;
    localparam logic [7:0] C_TRAIL_LO_MIN = 8'h40;
    localparam logic [7:0] C_TRAIL_LO_MAX = 8'h7e;
    localparam logic [7:0] C_TRAIL_HI_MIN = 8'h80;
    localparam logic [7:0] C_TRAIL_HI_MAX = 8'h9e;
    localparam logic [7:0] C_TRAIL_HI_OFS = 8'h41;
    localparam logic [7:0] C_TRAIL_OD_MIN = 8'h9f;
    localparam logic [7:0] C_TRAIL_OD_MAX = 8'hfc;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HALF,
        KIND_FULL,
        KIND_EXT_LOWER,
        KIND_EXT_UPPER
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BAD_BYTE,
        ERR_BAD_TRAIL,
        ERR_CUT_OFF
    } t_err;

    typedef struct packed {
        t_kind       glyph_kind;
        logic [6:0]  glyph_row;
        logic [6:0]  glyph_column;
        logic [7:0]  half_code;
        logic [4:0]  letter_index;
        t_err        error_code;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]  count;
        t_result     res0;
        t_result     res1;
    } t_dec;

    typedef struct packed {
        logic        emit;
        t_result     res;
        logic        set_dollar;
        logic        set_lead;
        logic [6:0]  row_base;
    } t_start;

endpackage

>>> rtl/sjgi_decoder.sv
// ----------------------------------------------------------------------------
// Shift-JIS glyph indexer byte decoder
// Holds the pending lead byte and dollar state and turns each accepted byte
// into zero, one or two result records.
// ----------------------------------------------------------------------------
`include "shift_jis_glyph_indexer_top_defines.svh"

module sjgi_decoder import sjgi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_text,
    output t_dec        o_dec
);

    logic       r_dollar_pending;
    logic       r_lead_pending;
    logic [6:0] r_row_base;
    logic       n_dollar_pending;
    logic       n_lead_pending;
    logic [6:0] n_row_base;
    t_dec       dec;

    function automatic t_start start_char(input logic [7:0] b, input logic eot);
        t_start     s;
        logic [7:0] ofs;
        s = '0;
        ofs = '0;
        if (b == C_DOLLAR) begin
            if (eot) begin
                s.emit = 1'b1;
                s.res.half_code = C_DOLLAR;
            end else begin
                s.set_dollar = 1'b1;
            end
        end else if (b <= C_ASCII_MAX || (b >= C_KANA_MIN && b <= C_KANA_MAX)) begin
            s.emit = 1'b1;
            s.res.half_code = b;
        end else if ((b >= C_LEAD1_MIN && b <= C_LEAD1_MAX) ||
                     (b >= C_LEAD2_MIN && b <= C_LEAD2_MAX)) begin
            if (eot) begin
                s.emit = 1'b1;
                s.res.error_code = ERR_CUT_OFF;
            end else begin
                ofs = (b <= C_LEAD1_MAX) ? (b - C_LEAD1_MIN) : (b - C_LEAD2_BIAS);
                s.set_lead = 1'b1;
                s.row_base = {ofs[5:0], 1'b0};
            end
        end else begin
            s.emit = 1'b1;
            s.res.error_code = ERR_BAD_BYTE;
        end
        return s;
    endfunction

    always_comb begin
        t_start     sc;
        logic [7:0] d;
        sc = '0;
        d = '0;
        dec = '0;
        n_dollar_pending = r_dollar_pending;
        n_lead_pending = r_lead_pending;
        n_row_base = r_row_base;
        if (r_lead_pending) begin
            n_lead_pending = 1'b0;
            dec.count = 2'd1;
            if (i_byte_in >= C_TRAIL_LO_MIN && i_byte_in <= C_TRAIL_LO_MAX) begin
                d = i_byte_in - C_TRAIL_LO_MIN;
                dec.res0.glyph_kind = KIND_FULL;
                dec.res0.glyph_row = r_row_base;
                dec.res0.glyph_column = d[6:0];
            end else if (i_byte_in >= C_TRAIL_HI_MIN && i_byte_in <= C_TRAIL_HI_MAX) begin
                d = i_byte_in - C_TRAIL_HI_OFS;
                dec.res0.glyph_kind = KIND_FULL;
                dec.res0.glyph_row = r_row_base;
                dec.res0.glyph_column = d[6:0];
            end else if (i_byte_in >= C_TRAIL_OD_MIN && i_byte_in <= C_TRAIL_OD_MAX) begin
                d = i_byte_in - C_TRAIL_OD_MIN;
                dec.res0.glyph_kind = KIND_FULL;
                dec.res0.glyph_row = r_row_base + 7'd1;
                dec.res0.glyph_column = d[6:0];
            end else begin
                dec.res0.error_code = ERR_BAD_TRAIL;
            end
        end else if (r_dollar_pending) begin
            n_dollar_pending = 1'b0;
            dec.count = 2'd1;
            if (i_byte_in >= C_LOWER_A && i_byte_in <= C_LOWER_Z) begin
                d = i_byte_in - C_LOWER_A;
                dec.res0.glyph_kind = KIND_EXT_LOWER;
                dec.res0.letter_index = d[4:0];
            end else if (i_byte_in >= C_UPPER_A && i_byte_in <= C_UPPER_Z) begin
                d = i_byte_in - C_UPPER_A;
                dec.res0.glyph_kind = KIND_EXT_UPPER;
                dec.res0.letter_index = d[4:0];
            end else if (i_byte_in == C_DOLLAR) begin
                dec.res0.half_code = C_DOLLAR;
            end else begin
                dec.res0.half_code = C_DOLLAR;
                sc = start_char(i_byte_in, i_end_of_text);
                if (sc.emit) begin
                    dec.count = 2'd2;
                    dec.res1 = sc.res;
                end
                n_dollar_pending = sc.set_dollar;
                n_lead_pending = sc.set_lead;
                if (sc.set_lead) begin
                    n_row_base = sc.row_base;
                end
            end
        end else begin
            sc = start_char(i_byte_in, i_end_of_text);
            dec.count = {1'b0, sc.emit};
            dec.res0 = sc.res;
            n_dollar_pending = sc.set_dollar;
            n_lead_pending = sc.set_lead;
            if (sc.set_lead) begin
                n_row_base = sc.row_base;
            end
        end
        if (i_end_of_text) begin
            n_dollar_pending = 1'b0;
            n_lead_pending = 1'b0;
        end
        if (dec.count == 2'd2) begin
            dec.res1.last_of_run = 1'b1;
        end else begin
            dec.res0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dollar_pending <= 1'b0;
            r_lead_pending <= 1'b0;
            r_row_base <= '0;
        end else if (i_accept) begin
            r_dollar_pending <= n_dollar_pending;
            r_lead_pending <= n_lead_pending;
            r_row_base <= n_row_base;
        end
    end

    assign o_dec = dec;

    `SJGI_ASSERT_NOW(a_one_pending, i_clk, i_rst_n, 1'b1, !(r_lead_pending && r_dollar_pending), "lead and dollar both pending")
    `SJGI_ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n, i_accept && i_end_of_text, !r_lead_pending && !r_dollar_pending, "state held after end of text")
    `SJGI_ASSERT_NOW(a_pair_dollar, i_clk, i_rst_n, dec.count == 2'd2, dec.res0.half_code == C_DOLLAR && !dec.res0.last_of_run, "two results without leading dollar")

endmodule

>>> rtl/sjgi_result_fifo.sv
// ----------------------------------------------------------------------------
// Shift-JIS glyph indexer result queue
// Small register queue that takes up to two result records per cycle and
// delivers one per cycle on the output channel while i_ready is high.
// ----------------------------------------------------------------------------
`include "shift_jis_glyph_indexer_top_defines.svh"

module sjgi_result_fifo import sjgi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_push_count,
    input  t_result     i_res0,
    input  t_result     i_res1,
    output logic        o_space_two,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_data
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic [FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  n_count;
    logic                   pop;

    assign o_valid = (r_count != '0);
    assign pop = o_valid && i_ready;
    assign o_data = r_mem[r_rd_ptr];
    assign o_space_two = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push_count);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count = r_count + FIFO_CNT_W'(i_push_count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_res1;
        end
    end

    `SJGI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FIFO_CNT_W'(FIFO_DEPTH), "queue count beyond depth")
    `SJGI_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push_count != 2'd0, {1'b0, r_count} + {{FIFO_CNT_W-1{1'b0}}, i_push_count} <= (FIFO_CNT_W+1)'(FIFO_DEPTH), "push into full queue")
    `SJGI_ASSERT_NEXT(a_empty_push, i_clk, i_rst_n, i_push_count != 2'd0 && r_count == '0, o_valid && o_data == $past(i_res0), "first pushed record not at head")

endmodule

>>> rtl/shift_jis_glyph_indexer_top.sv
// ----------------------------------------------------------------------------
// Shift-JIS glyph indexer
// Decodes a Shift-JIS byte stream into half-width, full-width row/column and
// external glyph addresses, with error results for malformed text.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while input ready is high and decoded in the
// same cycle into up to two result beats, which are registered in a four-entry
// result queue. The output delivers one beat per cycle while i_ready is high,
// so the sustained rate is one byte per cycle while bytes give at most one
// result; a byte that ends a lone dollar gives two beats. Input ready is high
// outside reset whenever the queue has two free entries, so a stalled output
// holds the input back only once three or more beats are waiting.
`include "shift_jis_glyph_indexer_top_defines.svh"

module shift_jis_glyph_indexer_top import sjgi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_glyph_kind,
    output logic [6:0]  o_glyph_row,
    output logic [6:0]  o_glyph_column,
    output logic [7:0]  o_half_code,
    output logic [4:0]  o_letter_index,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run
);

    logic       in_accept;
    logic       space_two;
    logic [1:0] push_count;
    t_dec       dec;
    t_result    head;

    assign o_ready = space_two && i_rst_n;
    assign in_accept = i_valid && o_ready;
    assign push_count = in_accept ? dec.count : 2'd0;

    sjgi_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte_in     (i_byte_in),
        .i_end_of_text (i_end_of_text),
        .o_dec         (dec)
    );

    sjgi_result_fifo u_result_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (dec.res0),
        .i_res1       (dec.res1),
        .o_space_two  (space_two),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (head)
    );

    assign o_glyph_kind = head.glyph_kind;
    assign o_glyph_row = head.glyph_row;
    assign o_glyph_column = head.glyph_column;
    assign o_half_code = head.half_code;
    assign o_letter_index = head.letter_index;
    assign o_error_code = head.error_code;
    assign o_last_of_run = head.last_of_run;

    `SJGI_ASSERT_NEXT(a_result_shows, i_clk, i_rst_n, in_accept && dec.count != 2'd0, o_valid, "accepted byte produced no output beat")
    `SJGI_ASSERT_NOW(a_count_legal, i_clk, i_rst_n, in_accept, dec.count != 2'd3, "decoder produced three results")
    `SJGI_ASSERT_NOW(a_last_on_single, i_clk, i_rst_n, in_accept && dec.count == 2'd1, dec.res0.last_of_run, "single result not marked last")

endmodule
